// ===== sv/bir_pkg.sv =====
package bir_pkg;

    localparam int MAX_WIDTH    = 4096;
    localparam int MAX_CHANNELS = 4;
    localparam int FRAC_BITS    = 16;
    localparam int MAX_UPSCALE  = 4;

    localparam int SPAN_CAP   = 2 * MAX_UPSCALE;
    localparam int SPAN_CNT_W = $clog2(SPAN_CAP + 2);
    localparam int SPAN_IDX_W = $clog2(SPAN_CAP);

    localparam int COORD_W     = $clog2(MAX_WIDTH);
    localparam int SIZE_W      = COORD_W + 1;
    localparam int OUT_COORD_W = 12;
    localparam int REG_SIZE_W  = 13;
    localparam int CHAN_REG_W  = 3;
    localparam int STEP_W      = 29;
    localparam int POS_W       = SIZE_W + STEP_W + 1;
    localparam int PIX_W       = 32;
    localparam int CH_IDX_W    = 2;

    localparam int H_W   = FRAC_BITS + 8;
    localparam int V_W   = 2 * FRAC_BITS + 8;
    localparam int A_W   = H_W + 1;
    localparam int MAC_W = A_W + FRAC_BITS + 1;

    localparam int STEP_LIMIT = (1 << FRAC_BITS) / MAX_UPSCALE;
    localparam int HALF_PIX   = 1 << (FRAC_BITS - 1);

    // Register index codes; register i sits at byte address 4 * i.
    localparam logic [2:0] REG_SRC_WIDTH  = 3'd0;
    localparam logic [2:0] REG_SRC_HEIGHT = 3'd1;
    localparam logic [2:0] REG_DST_WIDTH  = 3'd2;
    localparam logic [2:0] REG_DST_HEIGHT = 3'd3;
    localparam logic [2:0] REG_CHANNELS   = 3'd4;
    localparam logic [2:0] REG_X_STEP     = 3'd5;
    localparam logic [2:0] REG_Y_STEP     = 3'd6;

    typedef struct packed {
        logic [7:0] sample_c0;
        logic [7:0] sample_c1;
        logic [7:0] sample_c2;
        logic [7:0] sample_c3;
    } t_in_item;

    typedef struct packed {
        logic [7:0]             out_c0;
        logic [7:0]             out_c1;
        logic [7:0]             out_c2;
        logic [7:0]             out_c3;
        logic [OUT_COORD_W-1:0] dst_col;
        logic [OUT_COORD_W-1:0] dst_row;
        logic                   run_last;
        logic                   step_error;
    } t_out_item;

    typedef struct packed {
        logic [COORD_W-1:0]   key;
        logic [FRAC_BITS-1:0] frac;
    } t_tap;

    typedef struct packed {
        logic                 start;
        logic [CH_IDX_W-1:0]  ch_last;
        logic [PIX_W-1:0]     tl;
        logic [PIX_W-1:0]     tr;
        logic [PIX_W-1:0]     bl;
        logic [PIX_W-1:0]     br;
        logic [FRAC_BITS-1:0] fx;
        logic [FRAC_BITS-1:0] fy;
    } t_blend_req;

    typedef struct packed {
        logic             done;
        logic [PIX_W-1:0] pixel;
    } t_blend_resp;

    // Right-hand tap and fraction of a fixed-point position, clamped at both borders.
    function automatic t_tap axis_tap(input logic [POS_W-1:0] pos,
                                      input logic [SIZE_W-1:0] size);
        logic [POS_W-FRAC_BITS-1:0] s1;
        logic                       clamp;
        t_tap                       t;
        s1    = pos[POS_W-1] ? (POS_W-FRAC_BITS)'(1)
                             : {1'b0, pos[POS_W-2:FRAC_BITS]} + 1'b1;
        clamp = s1 >= (POS_W-FRAC_BITS)'(size);
        t.key  = clamp ? COORD_W'(size - 1'b1) : COORD_W'(s1);
        t.frac = (pos[POS_W-1] || clamp) ? '0 : pos[FRAC_BITS-1:0];
        return t;
    endfunction

    // Position of destination index zero: half a step minus half a pixel.
    function automatic logic [POS_W-1:0] axis_start(input logic [STEP_W-1:0] step);
        return POS_W'(step >> 1) - POS_W'(HALF_PIX);
    endfunction

endpackage

// ===== sv/bir_blend.sv =====
module bir_blend (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bir_pkg::t_blend_req  i_req,
    output bir_pkg::t_blend_resp o_resp
);

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_HT   = 3'd1;
    localparam logic [2:0] B_HB   = 3'd2;
    localparam logic [2:0] B_V    = 3'd3;
    localparam logic [2:0] B_RND  = 3'd4;

    localparam int F   = bir_pkg::FRAC_BITS;
    localparam int HWD = bir_pkg::H_W;
    localparam int VWD = bir_pkg::V_W;
    localparam int AWD = bir_pkg::A_W;
    localparam int MWD = bir_pkg::MAC_W;

    logic [2:0]                   r_state;
    logic [bir_pkg::CH_IDX_W-1:0] r_ch;
    logic [HWD-1:0]               r_ht;
    logic [HWD-1:0]               r_hb;
    logic [VWD-1:0]               r_v;
    logic [bir_pkg::PIX_W-1:0]    r_pix;
    logic                         r_done;

    logic [7:0]            tl_c, tr_c, bl_c, br_c;
    logic signed [AWD-1:0] mul_a;
    logic [F-1:0]          mul_b;
    logic [VWD-1:0]        mul_base;
    logic signed [F:0]     mul_bs;
    logic signed [MWD-1:0] prod;
    logic signed [MWD-1:0] mac;
    logic [7:0]            q;
    logic [2*F-1:0]        rem;
    logic                  round_up;
    logic [8:0]            q_rnd;
    logic [7:0]            q_sat;

    assign tl_c = i_req.tl[8*r_ch +: 8];
    assign tr_c = i_req.tr[8*r_ch +: 8];
    assign bl_c = i_req.bl[8*r_ch +: 8];
    assign br_c = i_req.br[8*r_ch +: 8];

    // One multiply-add serves all three passes: base + a*b, where each
    // weighted sum is rewritten as left*S + (right-left)*frac.
    always_comb begin
        case (r_state)
            B_HB: begin
                mul_a    = AWD'($signed({1'b0, br_c}) - $signed({1'b0, bl_c}));
                mul_b    = i_req.fx;
                mul_base = VWD'({bl_c, {F{1'b0}}});
            end
            B_V: begin
                mul_a    = $signed({1'b0, r_hb}) - $signed({1'b0, r_ht});
                mul_b    = i_req.fy;
                mul_base = {r_ht, {F{1'b0}}};
            end
            default: begin
                mul_a    = AWD'($signed({1'b0, tr_c}) - $signed({1'b0, tl_c}));
                mul_b    = i_req.fx;
                mul_base = VWD'({tl_c, {F{1'b0}}});
            end
        endcase
    end

    assign mul_bs = $signed({1'b0, mul_b});
    assign prod   = mul_a * mul_bs;
    assign mac    = prod + $signed({2'b00, mul_base});

    // Round half to even at the final fraction point, then saturate.
    assign q        = r_v[VWD-1:2*F];
    assign rem      = r_v[2*F-1:0];
    assign round_up = (rem > (2*F)'(1) << (2*F-1)) ||
                      ((rem == (2*F)'(1) << (2*F-1)) && q[0]);
    assign q_rnd    = {1'b0, q} + 9'(round_up);
    assign q_sat    = q_rnd[8] ? 8'hFF : q_rnd[7:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_ch    <= '0;
            r_ht    <= '0;
            r_hb    <= '0;
            r_v     <= '0;
            r_pix   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                B_IDLE: begin
                    if (i_req.start) begin
                        r_ch    <= '0;
                        r_pix   <= '0;
                        r_state <= B_HT;
                    end
                end
                B_HT: begin
                    r_ht    <= mac[HWD-1:0];
                    r_state <= B_HB;
                end
                B_HB: begin
                    r_hb    <= mac[HWD-1:0];
                    r_state <= B_V;
                end
                B_V: begin
                    r_v     <= mac[VWD-1:0];
                    r_state <= B_RND;
                end
                B_RND: begin
                    r_pix[8*r_ch +: 8] <= q_sat;
                    if (r_ch == i_req.ch_last) begin
                        r_done  <= 1'b1;
                        r_state <= B_IDLE;
                    end else begin
                        r_ch    <= r_ch + 1'b1;
                        r_state <= B_HT;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    assign o_resp.done  = r_done;
    assign o_resp.pixel = r_pix;

endmodule

// ===== sv/bilinear_image_resize_unit.sv =====
// Streaming bilinear resizer with half-pixel centers. Source pixels enter in
// raster order, one item per pixel with up to four 8-bit channels, and every
// destination pixel whose bottom-right tap is the incoming pixel leaves as one
// result item tagged with its destination column and row; run_last marks the
// last result of an input item. The block works on one item at a time and
// holds stall high while it does. Each item runs a column search and, on the
// first pixel of each source row, also a row search; each search walks
// destination indices one by one up to the index that ends it. The blend unit
// then computes every result channel by channel on its single shared
// multiply-add. An item whose results collapse into an error result skips the
// blend, and a result waits for as long as the output register is still held
// by the sink. A finished result waits in the output register, so the next
// item can be accepted while it is still stalled. Writing any register
// restarts the frame. An upscale beyond four times, or a step register below
// one quarter, replaces the due results of an item with a single result
// carrying step_error. The row memory is not cleared; changing the geometry in
// the middle of a frame can read stale entries.
module bilinear_image_resize_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  bir_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output bir_pkg::t_out_item o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int SW_W   = bir_pkg::SIZE_W;
    localparam int CW     = bir_pkg::COORD_W;
    localparam int PW     = bir_pkg::POS_W;
    localparam int STW    = bir_pkg::STEP_W;
    localparam int RSW    = bir_pkg::REG_SIZE_W;
    localparam int PXW    = bir_pkg::PIX_W;
    localparam int NW     = bir_pkg::SPAN_CNT_W;
    localparam int IW     = bir_pkg::SPAN_IDX_W;

    // Sequencer states.
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SCAN   = 4'd1;
    localparam logic [3:0] S_RD0    = 4'd2;
    localparam logic [3:0] S_RD1    = 4'd3;
    localparam logic [3:0] S_RD2    = 4'd4;
    localparam logic [3:0] S_BSTART = 4'd5;
    localparam logic [3:0] S_BWAIT  = 4'd6;
    localparam logic [3:0] S_EMIT   = 4'd7;
    localparam logic [3:0] S_ERR    = 4'd8;
    localparam logic [3:0] S_WB0    = 4'd9;
    localparam logic [3:0] S_WB1    = 4'd10;

    function automatic logic [SW_W-1:0] clamp_size(input logic [RSW-1:0] v,
                                                    input logic [SW_W-1:0] lo);
        logic [SW_W-1:0] res;
        if (32'(v) < 32'(lo)) begin
            res = lo;
        end else if (32'(v) > 32'(bir_pkg::MAX_WIDTH)) begin
            res = SW_W'(bir_pkg::MAX_WIDTH);
        end else begin
            res = SW_W'(v);
        end
        return res;
    endfunction

    // Configuration registers.
    logic [RSW-1:0]                 r_src_width, r_src_height;
    logic [RSW-1:0]                 r_dst_width, r_dst_height;
    logic [bir_pkg::CHAN_REG_W-1:0] r_channel_count;
    logic [STW-1:0]                 r_x_step, r_y_step;

    // Frame state.
    logic [3:0]      r_state;
    logic            r_restart_pend;
    logic [CW-1:0]   r_col_cnt, r_row_cnt;
    logic [SW_W-1:0] r_col_first, r_row_first;
    logic [PW-1:0]   r_x_pos, r_y_pos;
    logic [PXW-1:0]  r_left;

    // Current item.
    logic [PXW-1:0] r_cur;
    logic [CW-1:0]  r_c, r_r;
    logic [PXW-1:0] r_tl, r_tr;

    // Shared span search.
    logic            r_axis;
    logic [SW_W-1:0] r_sd;
    logic [PW-1:0]   r_spos;
    logic [CW-1:0]   r_sfirst;
    logic [NW-1:0]   r_sn;
    logic [PW-1:0]   r_sfirst_pos;

    // Spans found for this item and this row.
    logic [CW-1:0]   r_xfirst, r_yfirst;
    logic [NW-1:0]   r_nx, r_ny;
    logic [PW-1:0]   r_xfirst_pos, r_yfirst_pos;
    logic [SW_W-1:0] r_yend;
    logic [PW-1:0]   r_yend_pos;

    // Result walk.
    logic [IW-1:0]  r_ix, r_iy;
    logic [PW-1:0]  r_ox_pos, r_oy_pos;
    logic [PXW-1:0] r_pix;

    logic               r_out_valid;
    bir_pkg::t_out_item r_out_data;

    // Previous source row.
    logic [PXW-1:0] r_row_mem [bir_pkg::MAX_WIDTH];
    logic [PXW-1:0] r_mem_q;
    logic           mem_re, mem_we;
    logic [CW-1:0]  mem_ra, mem_wa;
    logic [PXW-1:0] mem_wd;

    logic [SW_W-1:0]            sw, sh, dw, dh;
    logic [bir_pkg::CH_IDX_W-1:0] ch_last;
    logic [PW-1:0]              pos0_x, pos0_y;
    logic                       in_accept, cfg_we, restart, last_col, out_free;
    logic [CW-1:0]              c_eff, r_eff;
    bir_pkg::t_tap              tap_s, tap_ox, tap_oy;
    logic [STW-1:0]             step_s;
    logic [SW_W-1:0]            lim_s;
    logic [CW-1:0]              tgt_s;
    logic                       span_err, last_x, last_y;
    bir_pkg::t_blend_req        blend_req;
    bir_pkg::t_blend_resp       blend_resp;

    assign sw = clamp_size(r_src_width, SW_W'(2));
    assign sh = clamp_size(r_src_height, SW_W'(2));
    assign dw = clamp_size(r_dst_width, '0);
    assign dh = clamp_size(r_dst_height, '0);

    always_comb begin
        if (r_channel_count == '0) begin
            ch_last = '0;
        end else if (32'(r_channel_count) > 32'(bir_pkg::MAX_CHANNELS)) begin
            ch_last = bir_pkg::CH_IDX_W'(bir_pkg::MAX_CHANNELS - 1);
        end else begin
            ch_last = bir_pkg::CH_IDX_W'(r_channel_count - 1'b1);
        end
    end

    assign pos0_x = bir_pkg::axis_start(r_x_step);
    assign pos0_y = bir_pkg::axis_start(r_y_step);

    assign in_accept = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign cfg_we    = psel && penable && pwrite;
    assign pready    = 1'b1;

    // A frame restarts after a register write or once the source counters
    // have run past the (possibly new) source size.
    assign restart = r_restart_pend || (SW_W'(r_col_cnt) >= sw) || (SW_W'(r_row_cnt) >= sh);
    assign c_eff   = restart ? '0 : r_col_cnt;
    assign r_eff   = restart ? '0 : r_row_cnt;

    // The span search walks destination indices on one axis at a time, one
    // index per cycle, stopping at the axis end or the first tap past this pixel.
    assign step_s = r_axis ? r_y_step : r_x_step;
    assign lim_s  = r_axis ? dh : dw;
    assign tgt_s  = r_axis ? r_r : r_c;
    assign tap_s  = bir_pkg::axis_tap(r_spos, r_axis ? sh : sw);

    assign last_col = (SW_W'(r_c) == sw - 1'b1);
    assign out_free = !r_out_valid || !i_out_stall;

    assign span_err = (32'(r_x_step) < 32'(bir_pkg::STEP_LIMIT)) ||
                      (32'(r_y_step) < 32'(bir_pkg::STEP_LIMIT)) ||
                      (32'(r_nx) > 32'(bir_pkg::SPAN_CAP)) ||
                      (32'(r_ny) > 32'(bir_pkg::SPAN_CAP));
    assign last_x = (NW'(r_ix) == r_nx - 1'b1);
    assign last_y = (NW'(r_iy) == r_ny - 1'b1);

    assign tap_ox = bir_pkg::axis_tap(r_ox_pos, sw);
    assign tap_oy = bir_pkg::axis_tap(r_oy_pos, sh);

    assign blend_req.start   = (r_state == S_BSTART);
    assign blend_req.ch_last = ch_last;
    assign blend_req.tl      = r_tl;
    assign blend_req.tr      = r_tr;
    assign blend_req.bl      = r_left;
    assign blend_req.br      = r_cur;
    assign blend_req.fx      = tap_ox.frac;
    assign blend_req.fy      = tap_oy.frac;

    bir_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (blend_req),
        .o_resp  (blend_resp)
    );

    // The row memory is read twice (left and right top taps) before the left
    // neighbour's pixel, and at the last column the item's own, is written back.
    assign mem_re = (r_state == S_RD0) || (r_state == S_RD1);
    assign mem_ra = (r_state == S_RD0) ? r_c - 1'b1 : r_c;
    assign mem_we = ((r_state == S_WB0) && (r_c != '0)) || ((r_state == S_WB1) && last_col);
    assign mem_wa = (r_state == S_WB0) ? r_c - 1'b1 : r_c;
    assign mem_wd = (r_state == S_WB0) ? r_left : r_cur;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_row_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_mem_q <= r_row_mem[mem_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width     <= RSW'(2);
            r_src_height    <= RSW'(2);
            r_dst_width     <= RSW'(2);
            r_dst_height    <= RSW'(2);
            r_channel_count <= bir_pkg::CHAN_REG_W'(1);
            r_x_step        <= STW'(65536);
            r_y_step        <= STW'(65536);
            r_state         <= S_IDLE;
            r_restart_pend  <= 1'b1;
            r_col_cnt       <= '0;
            r_row_cnt       <= '0;
            r_col_first     <= '0;
            r_row_first     <= '0;
            r_x_pos         <= '0;
            r_y_pos         <= '0;
            r_left          <= '0;
            r_cur           <= '0;
            r_c             <= '0;
            r_r             <= '0;
            r_tl            <= '0;
            r_tr            <= '0;
            r_axis          <= 1'b0;
            r_sd            <= '0;
            r_spos          <= '0;
            r_sfirst        <= '0;
            r_sn            <= '0;
            r_sfirst_pos    <= '0;
            r_xfirst        <= '0;
            r_yfirst        <= '0;
            r_nx            <= '0;
            r_ny            <= '0;
            r_xfirst_pos    <= '0;
            r_yfirst_pos    <= '0;
            r_yend          <= '0;
            r_yend_pos      <= '0;
            r_ix            <= '0;
            r_iy            <= '0;
            r_ox_pos        <= '0;
            r_oy_pos        <= '0;
            r_pix           <= '0;
            r_out_valid     <= 1'b0;
            r_out_data      <= '0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (cfg_we) begin
                case (paddr[4:2])
                    bir_pkg::REG_SRC_WIDTH:  r_src_width     <= pwdata[RSW-1:0];
                    bir_pkg::REG_SRC_HEIGHT: r_src_height    <= pwdata[RSW-1:0];
                    bir_pkg::REG_DST_WIDTH:  r_dst_width     <= pwdata[RSW-1:0];
                    bir_pkg::REG_DST_HEIGHT: r_dst_height    <= pwdata[RSW-1:0];
                    bir_pkg::REG_CHANNELS:
                        r_channel_count <= pwdata[bir_pkg::CHAN_REG_W-1:0];
                    bir_pkg::REG_X_STEP:     r_x_step        <= pwdata[STW-1:0];
                    bir_pkg::REG_Y_STEP:     r_y_step        <= pwdata[STW-1:0];
                    default: ;
                endcase
                if (paddr[4:2] <= bir_pkg::REG_Y_STEP) begin
                    r_restart_pend <= 1'b1;
                end
            end

            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_cur <= {i_in_data.sample_c3, i_in_data.sample_c2,
                                  i_in_data.sample_c1, i_in_data.sample_c0};
                        r_c   <= c_eff;
                        r_r   <= r_eff;
                        if (restart) begin
                            r_restart_pend <= 1'b0;
                            r_left         <= '0;
                            r_col_cnt      <= '0;
                            r_row_cnt      <= '0;
                            r_row_first    <= '0;
                            r_y_pos        <= pos0_y;
                        end
                        // The column span starts over at the first pixel of a row.
                        r_axis  <= 1'b0;
                        r_sn    <= '0;
                        r_sd    <= (c_eff == '0) ? '0 : r_col_first;
                        r_spos  <= (c_eff == '0) ? pos0_x : r_x_pos;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if ((r_sd < lim_s) && (tap_s.key <= tgt_s)) begin
                        if (tap_s.key == tgt_s) begin
                            if (r_sn == '0) begin
                                r_sfirst     <= r_sd[CW-1:0];
                                r_sfirst_pos <= r_spos;
                            end
                            if (32'(r_sn) <= 32'(bir_pkg::SPAN_CAP)) begin
                                r_sn <= r_sn + 1'b1;
                            end
                        end
                        r_sd   <= r_sd + 1'b1;
                        r_spos <= r_spos + PW'(step_s);
                    end else if (!r_axis) begin
                        r_col_first  <= r_sd;
                        r_x_pos      <= r_spos;
                        r_xfirst     <= r_sfirst;
                        r_nx         <= r_sn;
                        r_xfirst_pos <= r_sfirst_pos;
                        // The row span only changes between source rows, so it
                        // is searched once, on the first pixel of the row.
                        if (r_c == '0) begin
                            r_axis <= 1'b1;
                            r_sd   <= r_row_first;
                            r_spos <= r_y_pos;
                            r_sn   <= '0;
                        end else begin
                            r_state <= S_RD0;
                        end
                    end else begin
                        r_yfirst     <= r_sfirst;
                        r_ny         <= r_sn;
                        r_yfirst_pos <= r_sfirst_pos;
                        r_yend       <= r_sd;
                        r_yend_pos   <= r_spos;
                        r_state      <= S_RD0;
                    end
                end
                S_RD0: begin
                    r_state <= S_RD1;
                end
                S_RD1: begin
                    r_tl    <= (r_c == '0) ? '0 : r_mem_q;
                    r_state <= S_RD2;
                end
                S_RD2: begin
                    r_tr <= (r_c == '0) ? '0 : r_mem_q;
                    if ((r_nx != '0) && (r_ny != '0)) begin
                        if (span_err) begin
                            r_state <= S_ERR;
                        end else begin
                            r_ix     <= '0;
                            r_iy     <= '0;
                            r_ox_pos <= r_xfirst_pos;
                            r_oy_pos <= r_yfirst_pos;
                            r_state  <= S_BSTART;
                        end
                    end else begin
                        r_state <= S_WB0;
                    end
                end
                S_BSTART: begin
                    r_state <= S_BWAIT;
                end
                S_BWAIT: begin
                    if (blend_resp.done) begin
                        r_pix   <= blend_resp.pixel;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_valid           <= 1'b1;
                        r_out_data.out_c0     <= r_pix[7:0];
                        r_out_data.out_c1     <= r_pix[15:8];
                        r_out_data.out_c2     <= r_pix[23:16];
                        r_out_data.out_c3     <= r_pix[31:24];
                        r_out_data.dst_col    <= bir_pkg::OUT_COORD_W'(r_xfirst + CW'(r_ix));
                        r_out_data.dst_row    <= bir_pkg::OUT_COORD_W'(r_yfirst + CW'(r_iy));
                        r_out_data.run_last   <= last_x && last_y;
                        r_out_data.step_error <= 1'b0;
                        if (last_x && last_y) begin
                            r_state <= S_WB0;
                        end else if (last_x) begin
                            r_ix     <= '0;
                            r_iy     <= r_iy + 1'b1;
                            r_ox_pos <= r_xfirst_pos;
                            r_oy_pos <= r_oy_pos + PW'(r_y_step);
                            r_state  <= S_BSTART;
                        end else begin
                            r_ix     <= r_ix + 1'b1;
                            r_ox_pos <= r_ox_pos + PW'(r_x_step);
                            r_state  <= S_BSTART;
                        end
                    end
                end
                S_ERR: begin
                    if (out_free) begin
                        r_out_valid           <= 1'b1;
                        r_out_data.out_c0     <= '0;
                        r_out_data.out_c1     <= '0;
                        r_out_data.out_c2     <= '0;
                        r_out_data.out_c3     <= '0;
                        r_out_data.dst_col    <= bir_pkg::OUT_COORD_W'(r_xfirst);
                        r_out_data.dst_row    <= bir_pkg::OUT_COORD_W'(r_yfirst);
                        r_out_data.run_last   <= 1'b1;
                        r_out_data.step_error <= 1'b1;
                        r_state               <= S_WB0;
                    end
                end
                S_WB0: begin
                    r_state <= S_WB1;
                end
                S_WB1: begin
                    r_left <= r_cur;
                    if (last_col) begin
                        r_col_cnt <= '0;
                        if (SW_W'(r_r) == sh - 1'b1) begin
                            r_row_cnt   <= '0;
                            r_row_first <= '0;
                            r_y_pos     <= pos0_y;
                        end else begin
                            r_row_cnt   <= r_r + 1'b1;
                            r_row_first <= r_yend;
                            r_y_pos     <= r_yend_pos;
                        end
                    end else begin
                        r_col_cnt <= r_c + 1'b1;
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            bir_pkg::REG_SRC_WIDTH:  prdata = 32'(r_src_width);
            bir_pkg::REG_SRC_HEIGHT: prdata = 32'(r_src_height);
            bir_pkg::REG_DST_WIDTH:  prdata = 32'(r_dst_width);
            bir_pkg::REG_DST_HEIGHT: prdata = 32'(r_dst_height);
            bir_pkg::REG_CHANNELS:   prdata = 32'(r_channel_count);
            bir_pkg::REG_X_STEP:     prdata = 32'(r_x_step);
            bir_pkg::REG_Y_STEP:     prdata = 32'(r_y_step);
            default:                 prdata = '0;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
